### src/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

### src/mcof_pkg.sv
// Package for the matrix cofactor unit: sizes and register indexes
`timescale 1ns / 1ps
package mcof_pkg;
    localparam int MAX_ORDER_DEF  = 4;
    localparam int ENTRY_BITS_DEF = 8;
    localparam int RESULT_BITS    = 56;
    localparam int CFG_BITS       = 3;
    localparam logic [1:0] REG_ORDER   = 2'd0;
    localparam logic [1:0] REG_COF_ROW = 2'd1;
    localparam logic [1:0] REG_COF_COL = 2'd2;
endpackage

### src/matrix_cofactor_unit.sv
// Top level of the matrix cofactor unit
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Entries arrive one per cycle while the unit is loading and no result waits,
// and are written to a store. On the item marked last the unit checks the
// request; if it is valid, it computes the cofactor exactly in integers as a
// signed sum over the permutations of the minor's columns. It reads the store
// entries one at a time through a registered read port and multiplies each
// into a running product. Each permutation reads and multiplies one entry per
// minor row and then steps to the next permutation. Input is held off from the
// last entry until the result item has been taken. The store has no clearing
// pass; unwritten entries are never read.
module matrix_cofactor_unit
    import mcof_pkg::*;
#(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int ENTRY_BITS = ENTRY_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] entry
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [55:0] cofactor
    output logic        m_tuser,   // bad_input
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    localparam int CAP    = MAX_ORDER * MAX_ORDER;
    localparam int AW     = $clog2(CAP);
    localparam int CW     = $clog2(CAP + 2);
    localparam int MM     = MAX_ORDER - 1;
    localparam int IW     = (MM > 1) ? $clog2(MM) : 1;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_PERM = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // Store and registers
    logic signed [ENTRY_BITS-1:0] mem [CAP];
    logic signed [ENTRY_BITS-1:0] rd_data_reg;
    logic [2:0] state_reg;
    logic [CW-1:0] count_reg;
    logic [2:0] order_reg, row_reg, col_reg;
    logic [IW-1:0] perm_reg [MM];
    logic [IW-1:0] k_reg;
    logic sign_reg;
    logic signed [RESULT_BITS-1:0] prod_reg, acc_reg;
    logic bad_reg;
    logic [IW:0] m_reg;

    logic s_fire;
    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_LOAD) && !m_tvalid;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 3'd3;
            row_reg   <= 3'd1;
            col_reg   <= 3'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORDER:   order_reg <= cfg_data;
                REG_COF_ROW: row_reg   <= cfg_data;
                REG_COF_COL: col_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Map minor position (i, perm[i]) to a store address
    logic [IW-1:0] pk;
    logic [3:0] mr, mc;
    logic [AW-1:0] rd_addr;
    logic [7:0] lin;
    always_comb
    begin
        pk  = perm_reg[k_reg];
        mr  = {{(4-IW){1'b0}}, k_reg};
        mc  = {{(4-IW){1'b0}}, pk};
        if (mr >= {1'b0, row_reg} - 4'd1)
            mr = mr + 4'd1;
        if (mc >= {1'b0, col_reg} - 4'd1)
            mc = mc + 4'd1;
        lin     = mr * {5'd0, order_reg} + {4'd0, mc};
        rd_addr = lin[AW-1:0];
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (s_fire && count_reg < CW'(CAP))
            mem[count_reg[AW-1:0]] <= s_tdata[ENTRY_BITS-1:0];
        rd_data_reg <= mem[rd_addr];
    end

    // Next permutation in lexicographic order, with parity tracking
    logic [IW-1:0] np [MM];
    logic np_last, np_flip;
    always_comb
    begin
        int i, j, pi, pj;
        logic [IW-1:0] t;
        t  = '0;
        pj = 0;
        for (int q = 0; q < MM; q++)
            np[q] = perm_reg[q];
        np_last = 1'b1;
        np_flip = 1'b0;
        pi = -1;
        for (i = 0; i < MM - 1; i++)
            if (i < int'(m_reg) - 1 && perm_reg[i] < perm_reg[i+1])
                pi = i;
        if (pi >= 0)
        begin
            np_last = 1'b0;
            pj = pi + 1;
            for (j = 0; j < MM; j++)
                if (j > pi && j < int'(m_reg) && perm_reg[j] > perm_reg[pi])
                    pj = j;
            t = np[pi]; np[pi] = np[pj]; np[pj] = t;
            np_flip = 1'b1;
            // reverse tail pi+1 .. m-1
            for (j = 0; j < MM; j++)
            begin
                if (j > pi && j < int'(m_reg) && (pi + int'(m_reg) - j) > j)
                begin
                    t = np[j];
                    np[j] = np[pi + int'(m_reg) - j];
                    np[pi + int'(m_reg) - j] = t;
                    np_flip = ~np_flip;
                end
            end
        end
    end

    // Validity of the request
    logic bad_now;
    logic [CW-1:0] cnt_now;
    assign cnt_now = (count_reg <= CW'(CAP)) ? count_reg + CW'(1) : count_reg;
    assign bad_now = (order_reg < 3'd2) || ({29'd0, order_reg} > 32'(MAX_ORDER)) ||
                     (row_reg == 3'd0) || (row_reg > order_reg) ||
                     (col_reg == 3'd0) || (col_reg > order_reg) ||
                     ({{(8-CW){1'b0}}, cnt_now} != {5'd0, order_reg} * {5'd0, order_reg});

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            m_tvalid  <= 1'b0;
            acc_reg   <= '0;
            bad_reg   <= 1'b0;
            k_reg     <= '0;
            m_reg     <= '0;
            sign_reg  <= 1'b0;
            prod_reg  <= '0;
            for (int q = 0; q < MM; q++)
                perm_reg[q] <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;
            case (state_reg)
                ST_LOAD:
                begin
                    if (s_fire)
                    begin
                        if (s_tlast)
                        begin
                            count_reg <= '0;
                            acc_reg   <= '0;
                            bad_reg   <= bad_now;
                            m_reg     <= (IW+1)'(order_reg - 3'd1);
                            for (int q = 0; q < MM; q++)
                                perm_reg[q] <= IW'(q);
                            sign_reg  <= row_reg[0] ^ col_reg[0];
                            k_reg     <= '0;
                            prod_reg  <= RESULT_BITS'(1);
                            state_reg <= bad_now ? ST_OUT : ST_READ;
                        end
                        else
                            count_reg <= cnt_now;
                    end
                end
                ST_READ:
                    state_reg <= ST_MUL;
                ST_MUL:
                begin
                    // multiply running product by the entry just read
                    if ({1'b0, k_reg} == m_reg - (IW+1)'(1))
                    begin
                        acc_reg   <= sign_reg ? acc_reg - prod_reg * rd_data_reg
                                              : acc_reg + prod_reg * rd_data_reg;
                        state_reg <= ST_PERM;
                    end
                    else
                    begin
                        prod_reg  <= prod_reg * rd_data_reg;
                        k_reg     <= k_reg + IW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_PERM:
                begin
                    k_reg    <= '0;
                    prod_reg <= RESULT_BITS'(1);
                    if (np_last)
                        state_reg <= ST_OUT;
                    else
                    begin
                        for (int q = 0; q < MM; q++)
                            perm_reg[q] <= np[q];
                        sign_reg  <= sign_reg ^ np_flip;
                        state_reg <= ST_READ;
                    end
                end
                ST_OUT:
                begin
                    m_tvalid  <= 1'b1;
                    state_reg <= ST_LOAD;
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_tdata = bad_reg ? '0 : acc_reg;
    assign m_tuser = bad_reg;

    // Checks
    `ASSERT_IMPLIES(a_no_load_busy, clk, rst_n, state_reg != ST_LOAD, !s_tready)
    `ASSERT_NEXT(a_out_follows, clk, rst_n, state_reg == ST_OUT, m_tvalid)
    `ASSERT_IMPLIES(a_cnt_cap, clk, rst_n, 1'b1, count_reg <= CW'(CAP + 1))
endmodule

### tb/matrix_cofactor_unit_tb.sv
// Self-checking testbench for the matrix cofactor unit
`timescale 1ns / 1ps

// Scoreboard: mirrors the unit's store and registers and queues expected cofactors
class cofactor_scoreboard;
    logic signed [7:0] entries [16];
    int unsigned       n_entries;
    logic [2:0]        order;
    logic [2:0]        cof_row;
    logic [2:0]        cof_col;
    logic [55:0]       want_cof [$];
    logic              want_bad [$];
    int unsigned       errors;
    int unsigned       results_seen;
    int unsigned       flagged_seen;

    function new();
        n_entries = 0;
        order = 3'd3;
        cof_row = 3'd1;
        cof_col = 3'd1;
        errors = 0;
        results_seen = 0;
        flagged_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [2:0] val);
        case (idx)
            mcof_pkg::REG_ORDER:   order = val;
            mcof_pkg::REG_COF_ROW: cof_row = val;
            mcof_pkg::REG_COF_COL: cof_col = val;
            default: ;
        endcase
    endfunction

    // Determinant by first-row expansion of the leading k x k part
    function automatic longint det(longint a [4][4], int k);
        longint sub [4][4];
        longint sum;
        longint term;
        int y;
        sum = 0;
        if (k <= 0)
            return 1;
        if (k == 1)
            return a[0][0];
        for (int c = 0; c < k; c++)
        begin
            for (int r = 1; r < k; r++)
            begin
                y = 0;
                for (int x = 0; x < k; x++)
                begin
                    if (x != c)
                    begin
                        sub[r - 1][y] = a[r][x];
                        y++;
                    end
                end
            end
            term = a[0][c] * det(sub, k - 1);
            sum = (c % 2 == 1) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    // Note an accepted entry; on the last mark queue the expected cofactor
    function void note_entry(logic [7:0] data, logic last);
        longint m [4][4];
        longint res;
        int n;
        int a;
        int b;
        logic bad;
        if (n_entries < 16)
            entries[n_entries] = data;
        if (n_entries <= 16)
            n_entries++;
        if (!last)
            return;
        n = order;
        bad = (n < 2) || (n > 4) || (cof_row < 1) || (cof_row > n) ||
              (cof_col < 1) || (cof_col > n) || (n_entries != n * n);
        res = 0;
        if (!bad)
        begin
            a = 0;
            for (int r = 0; r < n; r++)
            begin
                if (r == cof_row - 1)
                    continue;
                b = 0;
                for (int c = 0; c < n; c++)
                begin
                    if (c == cof_col - 1)
                        continue;
                    m[a][b] = entries[r * n + c];
                    b++;
                end
                a++;
            end
            res = det(m, n - 1);
            if ((cof_row + cof_col) % 2 == 1)
                res = -res;
        end
        want_cof.push_back(res[55:0]);
        want_bad.push_back(bad);
        n_entries = 0;
    endfunction

    // Compare one result item with the oldest expectation
    function void check_result(logic [55:0] cof, logic bad);
        results_seen++;
        if (bad)
            flagged_seen++;
        if (want_cof.size() == 0)
        begin
            $display("%0t: unexpected result cofactor=%h bad=%b", $time, cof, bad);
            errors++;
            return;
        end
        if (cof !== want_cof[0])
        begin
            $display("%0t: cofactor expected %h actual %h", $time, want_cof[0], cof);
            errors++;
        end
        if (bad !== want_bad[0])
        begin
            $display("%0t: bad_input expected %b actual %b", $time, want_bad[0], bad);
            errors++;
        end
        void'(want_cof.pop_front());
        void'(want_bad.pop_front());
    endfunction
endclass

module matrix_cofactor_unit_tb;
    import mcof_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [2:0]  cfg_data;

    cofactor_scoreboard board;
    int unsigned idle_cycles;
    int unsigned entries_sent;
    int unsigned matrices_sent;
    bit          stall_free;

    matrix_cofactor_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if (stall_free)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    endfunction

    // Sample accepted items on the rising edge
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                board.note_entry(s_tdata, s_tlast);
                moved = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                board.check_result(m_tdata, m_tuser);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                board.write_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog expired, no progress", $time);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, driven on the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            int g;
            @(negedge clk);
            g = gap_len();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Drive one entry; valid stays high on return so entries can run back to back
    task automatic send_entry(logic [7:0] data, logic last);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        entries_sent++;
        if (last)
            matrices_sent++;
    endtask

    // Register write; only issued while the unit is idle, valid left high on return
    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Wait for every expected result, then let the unit finish any trailing work
    task automatic drain();
        while (board.want_cof.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic setup(int n, int row, int col);
        drain();
        write_reg(REG_ORDER, n[2:0]);
        write_reg(REG_COF_ROW, row[2:0]);
        write_reg(REG_COF_COL, col[2:0]);
        cfg_valid <= 1'b0;
    endtask

    // Send a matrix of count entries; mode 0 random, 1 all max, 2 all min
    task automatic send_matrix(int count, int mode);
        logic [7:0] v;
        for (int i = 0; i < count; i++)
        begin
            case (mode)
                1: v = 8'h7f;
                2: v = 8'h80;
                default: v = $urandom_range(0, 255);
            endcase
            send_entry(v, i == count - 1);
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        int n;
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cycles = 0;
        entries_sent = 0;
        matrices_sent = 0;
        stall_free = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, extremes of the entries, corners of the index
        send_matrix(9, 1);
        setup(4, 4, 4);
        send_matrix(16, 2);
        setup(2, 1, 2);
        send_matrix(4, 0);
        // Wrong count, index beyond the order, order out of range
        setup(3, 3, 3);
        send_matrix(5, 0);
        setup(2, 3, 1);
        send_matrix(4, 0);
        setup(1, 1, 1);
        send_matrix(1, 0);
        setup(5, 0, 0);
        send_matrix(2, 0);
        // Too many entries: saturating count
        setup(4, 2, 3);
        send_matrix(18, 0);
        // Stray write to the unused register index
        drain();
        write_reg(2'd3, 3'd5);
        cfg_valid <= 1'b0;

        // Random phases: mostly well-formed matrices, a few broken ones
        while (entries_sent < 680)
        begin
            n = $urandom_range(2, 4);
            stall_free = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
                setup($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
            else
                setup(n, $urandom_range(1, n), $urandom_range(1, n));
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_matrix($urandom_range(1, 18), 0);
                else
                    send_matrix(board.order * board.order > 0 &&
                                board.order <= 4 ? board.order * board.order : 4, 0);
            end
        end
        stall_free = 1'b0;
        drain();

        $display("Sent %0d entries in %0d matrices; checked %0d cofactors, %0d flagged bad.",
                 entries_sent, matrices_sent, board.results_seen, board.flagged_seen);
        if (board.errors == 0 && board.want_cof.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
